// File: rtl/sdss_pkg.sv
// Shared types, constants and segment tables for the signed decimal encoder.
`timescale 1ns / 1ps

package sdss_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int POS_W       = $clog2(DIGIT_COUNT);
  localparam int VALUE_W     = 16;
  localparam int MAG_W       = 14;
  localparam int SEG_W       = 7;
  localparam int DIGIT_W     = 4;
  localparam int PLACE_W     = 2;
  localparam int OUT_DATA_W  = 16;

  localparam logic signed [VALUE_W-1:0] MAX_SHOWN = 16'sd9999;
  localparam logic signed [VALUE_W-1:0] MIN_SHOWN = -16'sd999;

  localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;

  // Multiples k * 10^place, indexed [place][k].
  localparam logic [MAG_W-1:0] MULTIPLE [0:3][0:9] = '{
    '{14'd0, 14'd1,    14'd2,    14'd3,    14'd4,
      14'd5, 14'd6,    14'd7,    14'd8,    14'd9},
    '{14'd0, 14'd10,   14'd20,   14'd30,   14'd40,
      14'd50, 14'd60,  14'd70,   14'd80,   14'd90},
    '{14'd0, 14'd100,  14'd200,  14'd300,  14'd400,
      14'd500, 14'd600, 14'd700, 14'd800,  14'd900},
    '{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
      14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000}
  };

  // One number waiting to be shown: sign, magnitude, place of its leading digit.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [PLACE_W-1:0] place;
  } job_t;

  // Progress through one number: minus still pending, remainder, place, position.
  typedef struct packed {
    logic               neg;
    logic [MAG_W-1:0]   rem;
    logic [PLACE_W-1:0] place;
    logic [POS_W-1:0]   pos;
  } walk_t;

  function automatic logic [SEG_W-1:0] digit_segments(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/sdss_front.sv
// Input register: range check, sign/magnitude split and leading-digit place.
`timescale 1ns / 1ps

module sdss_front
  import sdss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [VALUE_W-1:0] s_tdata,   // [15:0] value
  output logic               job_valid,
  output job_t               job,
  input  logic               job_take
);

  logic signed [VALUE_W-1:0] value;
  logic                      in_range;
  logic [VALUE_W-1:0]        mag_full;
  job_t                      job_next;

  assign value    = $signed(s_tdata);
  assign in_range = (value <= MAX_SHOWN) && (value >= MIN_SHOWN);
  assign mag_full = value[VALUE_W-1] ? VALUE_W'(-value) : VALUE_W'(value);

  always_comb begin
    job_next.neg = value[VALUE_W-1];
    job_next.mag = mag_full[MAG_W-1:0];
    if (job_next.mag >= MAG_W'(1000)) begin
      job_next.place = 2'd3;
    end else if (job_next.mag >= MAG_W'(100)) begin
      job_next.place = 2'd2;
    end else if (job_next.mag >= MAG_W'(10)) begin
      job_next.place = 2'd1;
    end else begin
      job_next.place = 2'd0;
    end
  end

  // Slot is free when empty or handed on this cycle.
  assign s_tready = !job_valid || job_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      job_valid <= in_range;   // drop numbers that cannot be shown
    end else if (job_take) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      job <= job_next;
    end
  end

endmodule

// File: rtl/sdss_digit_step.sv
// One character step: minus sign or next digit by compare and subtract.
`timescale 1ns / 1ps

module sdss_digit_step
  import sdss_pkg::*;
(
  input  walk_t            cur,
  output logic [SEG_W-1:0] seg,
  output logic             last,
  output walk_t            adv
);

  logic [DIGIT_W-1:0] digit;

  always_comb begin
    digit = '0;
    for (int k = 1; k < 10; k++) begin
      if (cur.rem >= MULTIPLE[cur.place][DIGIT_W'(k)]) begin
        digit = DIGIT_W'(k);
      end
    end
  end

  always_comb begin
    adv     = cur;
    adv.pos = cur.pos + POS_W'(1);
    if (cur.neg) begin
      seg     = SEG_MINUS;
      last    = 1'b0;
      adv.neg = 1'b0;
    end else begin
      seg       = digit_segments(digit);
      last      = (cur.place == '0);
      adv.rem   = cur.rem - MULTIPLE[cur.place][digit];
      adv.place = cur.place - PLACE_W'(1);
    end
  end

endmodule

// File: rtl/signed_decimal_seven_segment_encoder.sv
// Top level: signed number in, one seven-segment character word per display position out.
`timescale 1ns / 1ps

// Usage
//   Slave channel (s_*): one word per number, s_tdata holds a 16-bit signed value.
//   Master channel (m_*): one word per character, left to right. m_tdata carries the
//   display position and the gfedcba pattern; m_tlast marks the final character.
//   A negative number starts with a minus sign (segment g) at position 0.
//   Numbers above 9999 or below -999 are accepted and dropped without output.
// With the walker idle, the first character of a number reaches m_tdata through the
//   input register, then the output register.
// Throughput: one character word per cycle while the receiver does not stall, and a
//   number has one to four characters. The character walker emits a minus sign if needed,
//   then the digits from the leading one, finding each digit by comparing the remainder
//   against its nine multiples of the current power of ten, so each cycle resolves exactly one character.
// A new number is taken while the previous one is still being shown: the input
//   register holds the next number until the walker finishes the current one.
// Reset clears the input slot, the walker and the output valid; a number in flight
//   is lost. When the receiver stalls, the output word holds and the walker and the
//   input register stop in place, so nothing is lost or repeated.

module signed_decimal_seven_segment_encoder
  import sdss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [VALUE_W-1:0]    s_tdata,   // [15:0] value (signed)
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [1:0] digit_position, [8:2] segments, [15:9] zero
  output logic                  m_tlast    // last
);

  logic             job_valid;
  job_t             job;
  logic             job_take;

  // Walker state for the number being shown.
  logic             active;
  walk_t            walk;

  walk_t            cur;
  walk_t            adv;
  logic [SEG_W-1:0] step_seg;
  logic             step_last;
  logic             have_src;
  logic             out_load;

  // Output register payload.
  logic [POS_W-1:0] pos_q;
  logic [SEG_W-1:0] seg_q;
  logic             last_q;

  sdss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  // Output register can take a word when empty or being drained.
  assign out_load = !m_tvalid || m_tready;

  // Continue the current number, or start the waiting one directly from the input
  // register without first loading it into the walker.
  always_comb begin
    if (active) begin
      cur = walk;
    end else begin
      cur.neg   = job.neg;
      cur.rem   = job.mag;
      cur.place = job.place;
      cur.pos   = '0;
    end
  end

  assign have_src = active || job_valid;
  assign job_take = out_load && !active && job_valid;

  sdss_digit_step u_step (
    .cur  (cur),
    .seg  (step_seg),
    .last (step_last),
    .adv  (adv)
  );

  // Control: output valid and walker activity.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      active   <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= have_src;
      if (have_src) begin
        active <= !step_last;   // drop out after the final character
      end
    end
  end

  // Payload: advance the walker and load the output word together.
  always_ff @(posedge clk) begin
    if (out_load && have_src) begin
      walk   <= adv;
      pos_q  <= cur.pos;
      seg_q  <= step_seg;
      last_q <= step_last;
    end
  end

  assign m_tdata = {(OUT_DATA_W - SEG_W - POS_W)'(0), seg_q, pos_q};
  assign m_tlast = last_q;

endmodule
